// ===== rtl/ecc_pkg.sv =====
// ---------------------------------------------------------------------------
// Epoch calendar converter package
// Stage record, fixed constants and the month start table.
// ---------------------------------------------------------------------------
package ecc_pkg;

  localparam logic CMD_TO_CAL  = 1'b0;
  localparam logic CMD_TO_SECS = 1'b1;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 96;

  localparam logic [9:0]  MS_MAX       = 10'd999;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [11:0] SECS_PER_HR  = 12'd3600;
  localparam logic [10:0] CYC_DAYS     = 11'd1461;

  // floor(x / d) as (x * RECIP) >> SHIFT, exact over the operand range used
  localparam logic [25:0] RECIP_DAY  = 26'd50903317; // (secs >> 7) / 675, shift 35
  localparam logic [16:0] RECIP_CYC  = 17'd91868;    // days / 1461, shift 27
  localparam logic [13:0] RECIP_HOUR = 14'd9321;     // (sod >> 4) / 225, shift 21
  localparam logic [10:0] RECIP_MIN  = 11'd1093;     // (rem >> 2) / 15, shift 14

  typedef struct packed {
    logic        cmd;
    logic        ok;
    logic [9:0]  ms;
    logic [31:0] secs;
    logic [16:0] dsec;
    logic [15:0] days;
    logic [16:0] sod;
    logic [5:0]  cyc;
    logic [4:0]  hour;
    logic [10:0] cr;
    logic [11:0] remh;
    logic [11:0] year;
    logic        leap;
    logic [8:0]  doy;
    logic [5:0]  minute;
  } ecc_stage_t;

  function automatic logic [8:0] ecc_month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      4'd12:   base = 9'd365;
      default: base = 9'd365;
    endcase
    return base + 9'((leap && (idx >= 4'd2)) ? 1 : 0);
  endfunction

endpackage

// ===== rtl/ecc_datapath.sv =====
// ---------------------------------------------------------------------------
// Epoch calendar converter datapath
// Six register stages; each stage loads when its enable bit is set.
// ---------------------------------------------------------------------------
module ecc_datapath #(
  parameter int unsigned BASE_YEAR = 1970,
  parameter int unsigned YEAR_SPAN = 100
) (
  input  logic                         clk_i,
  input  logic [5:0]                   en_i,
  input  logic                         cmd_i,
  input  logic [ecc_pkg::InDataW-1:0]  data_i,
  output logic                         res_ok_o,
  output logic [ecc_pkg::OutDataW-1:0] res_data_o
);

  localparam int unsigned RemYear    = BASE_YEAR % 4;
  localparam int unsigned AlignYear  = BASE_YEAR - RemYear;
  localparam int unsigned AlignDays  = 365 * RemYear + ((RemYear > 0) ? 1 : 0);
  localparam int unsigned LeapsBase  = (BASE_YEAR - 1) / 4;
  localparam int unsigned LimitLeaps = (BASE_YEAR + YEAR_SPAN - 1) / 4 - LeapsBase;
  localparam longint      LimitL     = (longint'(YEAR_SPAN) * 365 + longint'(LimitLeaps))
                                       * 86400;
  localparam logic [32:0] Limit      = 33'(LimitL);

  ecc_pkg::ecc_stage_t r1_q, r1_d, r2_q, r2_d, r3_q, r3_d, r4_q, r4_d, r5_q, r5_d;
  logic                         res_ok_q, res_ok_d;
  logic [ecc_pkg::OutDataW-1:0] res_data_q, res_data_d;

  // stage 1: unpack, range checks, day count
  logic [31:0] in_secs;
  logic [9:0]  in_ms;
  logic [11:0] in_year;
  logic [3:0]  in_month, mon1;
  logic [4:0]  in_day, day1;
  logic [16:0] in_dsec;
  logic [50:0] prod1;
  logic [7:0]  k1, leaps1;
  logic [8:0]  mstart1;
  logic [15:0] days1;
  logic        ok0, ok1;

  always_comb begin
    in_secs  = data_i[31:0];
    in_ms    = data_i[41:32];
    in_year  = data_i[53:42];
    in_month = data_i[57:54];
    in_day   = data_i[62:58];
    in_dsec  = data_i[79:63];
    mon1     = (in_month == 4'd0) ? 4'd1 : ((in_month > 4'd12) ? 4'd12 : in_month);
    day1     = (in_day == 5'd0) ? 5'd1 : in_day;
    k1       = 8'(in_year - 12'(BASE_YEAR));
    leaps1   = 8'(((in_year - 12'd1) >> 2) - 12'(LeapsBase));
    mstart1  = ecc_pkg::ecc_month_start(in_year[1:0] == 2'd0, mon1 - 4'd1);
    days1    = 16'(k1) * 16'd365 + 16'(leaps1) + 16'(mstart1) + 16'(day1 - 5'd1);
    ok1      = (in_year >= 12'(BASE_YEAR)) && ({1'b0, in_year} < 13'(BASE_YEAR + YEAR_SPAN));
    ok0      = !(({1'b0, in_secs} > Limit) || (({1'b0, in_secs} == Limit) && (in_ms != 10'd0)));
    prod1    = 51'(in_secs[31:7]) * 51'(ecc_pkg::RECIP_DAY);
    r1_d       = '0;
    r1_d.cmd   = cmd_i;
    r1_d.ms    = (in_ms > ecc_pkg::MS_MAX) ? ecc_pkg::MS_MAX : in_ms;
    r1_d.secs  = in_secs;
    r1_d.dsec  = in_dsec;
    r1_d.ok    = (cmd_i == ecc_pkg::CMD_TO_SECS) ? ok1 : ok0;
    r1_d.days  = (cmd_i == ecc_pkg::CMD_TO_SECS) ? days1 : prod1[50:35];
  end

  // stage 2: days times seconds per day
  logic [32:0] prod2;
  logic [31:0] diff2;

  always_comb begin
    prod2 = 33'(r1_q.days) * 33'(ecc_pkg::SECS_PER_DAY);
    diff2 = r1_q.secs - prod2[31:0];
    r2_d  = r1_q;
    if (r1_q.cmd == ecc_pkg::CMD_TO_SECS) begin
      r2_d.secs = prod2[31:0];
    end else begin
      r2_d.sod  = diff2[16:0];
      r2_d.days = r1_q.days + 16'(AlignDays);
    end
  end

  // stage 3: four-year cycle and hour
  logic [32:0] prod3a;
  logic [26:0] prod3b;

  always_comb begin
    prod3a = 33'(r2_q.days) * 33'(ecc_pkg::RECIP_CYC);
    prod3b = 27'(r2_q.sod[16:4]) * 27'(ecc_pkg::RECIP_HOUR);
    r3_d   = r2_q;
    if (r2_q.cmd == ecc_pkg::CMD_TO_SECS) begin
      r3_d.secs = r2_q.secs + 32'(r2_q.dsec);
    end else begin
      r3_d.cyc  = prod3a[32:27];
      r3_d.hour = prod3b[25:21];
    end
  end

  // stage 4: remainders
  logic [15:0] cr4;
  logic [16:0] remh4;

  always_comb begin
    cr4     = r3_q.days - 16'(r3_q.cyc) * 16'(ecc_pkg::CYC_DAYS);
    remh4   = r3_q.sod - 17'(r3_q.hour) * 17'(ecc_pkg::SECS_PER_HR);
    r4_d      = r3_q;
    r4_d.cr   = cr4[10:0];
    r4_d.remh = remh4[11:0];
  end

  // stage 5: year within cycle, minute
  logic [20:0] prod5;
  logic [1:0]  y5;
  logic [10:0] doy5;

  always_comb begin
    prod5 = 21'(r4_q.remh[11:2]) * 21'(ecc_pkg::RECIP_MIN);
    if (r4_q.cr < 11'd366) begin
      y5   = 2'd0;
      doy5 = r4_q.cr;
    end else if (r4_q.cr < 11'd731) begin
      y5   = 2'd1;
      doy5 = r4_q.cr - 11'd366;
    end else if (r4_q.cr < 11'd1096) begin
      y5   = 2'd2;
      doy5 = r4_q.cr - 11'd731;
    end else begin
      y5   = 2'd3;
      doy5 = r4_q.cr - 11'd1096;
    end
    r5_d        = r4_q;
    r5_d.minute = prod5[19:14];
    r5_d.leap   = (y5 == 2'd0);
    r5_d.doy    = doy5[8:0];
    r5_d.year   = 12'(AlignYear) + {4'd0, r4_q.cyc, 2'b00} + 12'(y5);
  end

  // stage 6: month, day, second, result packing
  logic [3:0]  mon6;
  logic [8:0]  dom6;
  logic [11:0] sec6;
  logic [8:0]  doy6;

  always_comb begin
    mon6 = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if (ecc_pkg::ecc_month_start(r5_q.leap, 4'(i)) <= r5_q.doy) begin
        mon6 = 4'(i + 1);
      end
    end
    dom6 = r5_q.doy - ecc_pkg::ecc_month_start(r5_q.leap, mon6 - 4'd1) + 9'd1;
    sec6 = r5_q.remh - 12'(r5_q.minute) * 12'd60;
    doy6 = r5_q.doy + 9'd1;
    res_ok_d   = r5_q.ok;
    res_data_d = '0;
    if (r5_q.ok) begin
      res_data_d[41:32] = r5_q.ms;
      if (r5_q.cmd == ecc_pkg::CMD_TO_SECS) begin
        res_data_d[31:0] = r5_q.secs;
      end else begin
        res_data_d[53:42] = r5_q.year;
        res_data_d[57:54] = mon6;
        res_data_d[62:58] = dom6[4:0];
        res_data_d[67:63] = r5_q.hour;
        res_data_d[73:68] = r5_q.minute;
        res_data_d[79:74] = sec6[5:0];
        res_data_d[88:80] = doy6;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) r1_q <= r1_d;
    if (en_i[1]) r2_q <= r2_d;
    if (en_i[2]) r3_q <= r3_d;
    if (en_i[3]) r4_q <= r4_d;
    if (en_i[4]) r5_q <= r5_d;
    if (en_i[5]) begin
      res_ok_q   <= res_ok_d;
      res_data_q <= res_data_d;
    end
  end

  assign res_ok_o   = res_ok_q;
  assign res_data_o = res_data_q;

endmodule

// ===== rtl/epoch_calendar_converter_core.sv =====
// ---------------------------------------------------------------------------
// Epoch calendar converter core
// Converts seconds since BASE_YEAR to calendar fields and back.
// ---------------------------------------------------------------------------
// Takes one item per clock, unless a stalled output has filled every stage. The
// datapath has six register stages: unpack and day count,
// day split, cycle and hour split, remainders, year and minute, and month with
// the output register. The first stage loads at the accepting edge. Each stage
// advances on its own, so a stalled output only holds back the stages behind
// it and bubbles are squeezed out. tuser on the input is the command, tuser on
// the output is the valid flag of the result.
module epoch_calendar_converter_core #(
  parameter int unsigned BASE_YEAR = 1970,
  parameter int unsigned YEAR_SPAN = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // epoch_seconds_in[31:0], millisecond_in[41:32], year_in[53:42],
  // month_in[57:54], day_in[62:58], day_seconds_in[79:63]
  input  logic [79:0] s_axis_tdata,
  // command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // epoch_seconds_out[31:0], millisecond_out[41:32], year_out[53:42],
  // month_out[57:54], day_out[62:58], hour_out[67:63], minute_out[73:68],
  // second_out[79:74], day_of_year_out[88:80], zero[95:89]
  output logic [95:0] m_axis_tdata,
  // valid_res
  output logic        m_axis_tuser
);

  logic [5:0] vld_q, vld_d;
  logic [5:0] en;

  always_comb begin
    en[5] = !vld_q[5] || m_axis_tready;
    for (int i = 4; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i + 1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int i = 1; i < 6; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  ecc_datapath #(
    .BASE_YEAR(BASE_YEAR),
    .YEAR_SPAN(YEAR_SPAN)
  ) u_datapath (
    .clk_i     (clk_i),
    .en_i      (en),
    .cmd_i     (s_axis_tuser),
    .data_i    (s_axis_tdata),
    .res_ok_o  (m_axis_tuser),
    .res_data_o(m_axis_tdata)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[5];

endmodule

// ===== rtl/ecc_checker.sv =====
// ---------------------------------------------------------------------------
// Epoch calendar converter checker
// Port level assertions, bound to the core.
// ---------------------------------------------------------------------------
module ecc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input held back without a stalled result");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 96'd0)
    else $error("invalid result carries data");

  a_ms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[41:32] <= 10'd999)
    else $error("millisecond out of range");

  a_cal_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[57:54] != 4'd0 |->
      m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[62:58] != 5'd0 &&
      m_axis_tdata[67:63] < 5'd24 && m_axis_tdata[73:68] < 6'd60 &&
      m_axis_tdata[79:74] < 6'd60 && m_axis_tdata[57:54] <= 4'd12)
    else $error("calendar fields out of range");

endmodule

bind epoch_calendar_converter_core ecc_checker u_ecc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
